// ===== sv/sopsc_pkg.sv =====
// Shared types and constants for the segmented odd prime sieve counter.
// Used by the sieve cell, the serial divider and the core; depends on nothing.
package sopsc_pkg;

    localparam int IN_W  = 21;
    localparam int CNT_W = 20;
    localparam int PC_W  = 7;
    localparam int PI_W  = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_PART_COUNT = 1'b0;
    localparam logic REG_PART_INDEX = 1'b1;

    typedef struct packed {
        logic valid;
        logic mark;
        logic taken;
    } t_ctl;

    function automatic int isqrt(input longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x) begin
                r = t;
            end
        end
        return int'(r);
    endfunction

endpackage

// ===== sv/sopsc_cell.sv =====
// One sieve cell: captures a base prime and strikes its odd multiples as candidates pass.
// Depends on sopsc_pkg for the control beat type.
module sopsc_cell #(
    parameter int VW = 21,
    parameter int PW = 11,
    parameter int SQ = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  sopsc_pkg::t_ctl    i_ctl,
    input  logic [VW-1:0]      i_v,
    output sopsc_pkg::t_ctl    o_ctl,
    output logic [VW-1:0]      o_v
);
    import sopsc_pkg::*;

    logic          r_full;
    logic [PW-1:0] r_p;
    logic [VW:0]   r_m;
    t_ctl          r_ctl;
    logic [VW-1:0] r_v;
    logic          hit;
    logic          cap;

    assign hit = i_ctl.valid && r_full && ({1'b0, i_v} == r_m);
    assign cap = i_ctl.valid && !r_full && !i_ctl.mark && !i_ctl.taken
                 && (i_v <= VW'(SQ));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_full <= 1'b0;
            r_ctl  <= '0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
            r_ctl.mark  <= i_ctl.mark | hit;
            r_ctl.taken <= i_ctl.taken | cap;
            if (cap) begin
                r_full <= 1'b1;
            end
        end
        r_v <= i_v;
        if (cap) begin
            r_p <= i_v[PW-1:0];
            r_m <= ({1'b0, i_v} << 1) + {1'b0, i_v};
        end else if (hit) begin
            r_m <= r_m + (VW+1)'({r_p, 1'b0});
        end
    end

    assign o_ctl = r_ctl;
    assign o_v   = r_v;

endmodule

// ===== sv/sopsc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the share bounds.
// Depends on sopsc_pkg for the divisor width.
module sopsc_div #(
    parameter int DW = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [sopsc_pkg::PC_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [DW-1:0]              o_quot
);
    import sopsc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [PC_W:0] r_rem;
    logic [PC_W-1:0] r_d;
    logic [PC_W:0] rem_sh;
    logic          ge;

    assign rem_sh = {r_rem[PC_W-1:0], r_q[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_d} : rem_sh;
            r_q   <= {r_q[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/segmented_odd_prime_sieve_count_core.sv =====
// Segmented odd-only prime sieve counter: a chain of sieve cells fed with odd candidates.
// Depends on sopsc_pkg, sopsc_div and sopsc_cell.
// Candidates stream through the cell chain, one odd number a cycle, from 3 up to the share's top.
// One request is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset clears control state and sets part_count 1, part_index 0.
module segmented_odd_prime_sieve_count_core #(
    parameter int MAX_N     = 1048576,
    parameter int MAX_PARTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sopsc_pkg::IN_W-1:0]  i_limit_n,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sopsc_pkg::CNT_W-1:0] o_odd_prime_count,
    output logic [sopsc_pkg::CNT_W-1:0] o_prime_count_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sopsc_pkg::ADDR_W-1:0] paddr,
    input  logic [sopsc_pkg::DATA_W-1:0] pwdata,
    output logic [sopsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import sopsc_pkg::*;

    localparam int VW    = $clog2(MAX_N + 1);
    localparam int SQ    = isqrt(longint'(MAX_N));
    localparam int PW    = $clog2(SQ + 1);
    localparam int NCELL = SQ / 3 + 2;
    localparam int DW    = VW + PC_W;
    localparam int DRW   = $clog2(NCELL + 3);
    localparam int EW    = VW + IN_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_DIV2, S_RUN, S_DRAIN, S_DONE
    } t_state;

    t_state            r_state;
    logic [PC_W-1:0]   r_part_count;
    logic [PI_W-1:0]   r_part_index;
    logic [VW-1:0]     r_n;
    logic [PC_W-1:0]   r_cnt;
    logic [PC_W-1:0]   r_idx;
    logic              r_empty;
    logic [VW:0]       r_lo;
    logic [VW:0]       r_hi;
    logic [VW:0]       r_v;
    logic [DRW-1:0]    r_drain;
    logic [CNT_W-1:0]  r_count;
    logic              r_clr;
    logic              r_div_start;
    logic [DW-1:0]     r_dividend;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_odd;
    logic [CNT_W-1:0]  r_tot;
    t_ctl              r_inj;
    logic [VW-1:0]     r_inj_v;

    logic              cfg_wr;
    logic [EW-1:0]     n_ext;
    logic [VW-1:0]     n_clamp;
    logic [PC_W-1:0]   cnt_eff;
    logic [VW-1:0]     nm1;
    logic              div_done;
    logic [DW-1:0]     quot;
    logic [VW:0]       lo_raw;
    logic [VW:0]       hi_raw;
    logic              tail_hit;

    t_ctl              ctl_c [0:NCELL];
    logic [VW-1:0]     v_c   [0:NCELL];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_PART_COUNT) ? DATA_W'(r_part_count)
                                                 : DATA_W'(r_part_index);

    assign n_ext   = EW'(i_limit_n);
    assign n_clamp = (n_ext > EW'(MAX_N)) ? VW'(MAX_N) :
                     (n_ext < EW'(2))     ? VW'(2)     : n_ext[VW-1:0];
    assign cnt_eff = (r_part_count == '0) ? PC_W'(1) :
                     (int'(r_part_count) > MAX_PARTS) ? PC_W'(MAX_PARTS) : r_part_count;
    assign nm1     = r_n - 1'b1;
    assign lo_raw  = (VW+1)'(quot) + (VW+1)'(2);
    assign hi_raw  = (VW+1)'(quot) + (VW+1)'(1);
    assign o_ready = (r_state == S_IDLE);

    assign tail_hit = ctl_c[NCELL].valid && !ctl_c[NCELL].mark && !r_empty
                      && ({1'b0, v_c[NCELL]} >= r_lo) && ({1'b0, v_c[NCELL]} <= r_hi);

    sopsc_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign ctl_c[0] = r_inj;
    assign v_c[0]   = r_inj_v;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        sopsc_cell #(.VW(VW), .PW(PW), .SQ(SQ)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (r_clr),
            .i_ctl   (ctl_c[g]),
            .i_v     (v_c[g]),
            .o_ctl   (ctl_c[g+1]),
            .o_v     (v_c[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_part_count <= PC_W'(1);
            r_part_index <= '0;
            r_clr        <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_inj        <= '0;
        end else begin
            r_clr       <= 1'b0;
            r_div_start <= 1'b0;
            r_inj       <= '0;
            if (cfg_wr) begin
                if (paddr[2] == REG_PART_COUNT) begin
                    r_part_count <= pwdata[PC_W-1:0];
                end else begin
                    r_part_index <= pwdata[PI_W-1:0];
                end
            end
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n         <= n_clamp;
                        r_cnt       <= cnt_eff;
                        r_idx       <= PC_W'(r_part_index);
                        r_empty     <= PC_W'(r_part_index) >= cnt_eff;
                        r_dividend  <= DW'(r_part_index) * DW'(n_clamp - 1'b1);
                        r_div_start <= 1'b1;
                        r_clr       <= 1'b1;
                        r_count     <= '0;
                        r_state     <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_lo        <= lo_raw | (VW+1)'(1);
                        r_dividend  <= (DW'(r_idx) + DW'(1)) * DW'(nm1);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_hi    <= hi_raw[0] ? hi_raw : hi_raw - 1'b1;
                        r_v     <= (VW+1)'(3);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!r_empty && r_v <= r_hi) begin
                        r_inj.valid <= 1'b1;
                        r_inj_v     <= r_v[VW-1:0];
                        r_v         <= r_v + (VW+1)'(2);
                    end else begin
                        r_drain <= DRW'(NCELL + 2);
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain - 1'b1;
                    if (r_drain == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_odd       <= r_count;
                        r_tot       <= r_count + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (tail_hit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_odd_prime_count   = r_odd;
    assign o_prime_count_total = r_tot;

    a_tail_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_c[NCELL].valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("candidate left the chain outside a sweep");

    a_div_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside the bound phase");

    a_odd_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj.valid |-> r_inj_v[0])
        else $error("even candidate entered the chain");

endmodule

// ===== dv/segmented_odd_prime_sieve_count_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for segmented_odd_prime_sieve_count_core: limits go in, and each
// count is checked against a table of odd-prime counts. Depends on sopsc_pkg and the core.
module segmented_odd_prime_sieve_count_core_tb;
    import sopsc_pkg::*;

    localparam int MAX_N     = 1048576;
    localparam int MAX_PARTS = 64;
    localparam int LIMIT_CYCLES = 6000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [IN_W-1:0]     i_limit_n = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [CNT_W-1:0]    o_odd_prime_count;
    logic [CNT_W-1:0]    o_prime_count_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    typedef struct packed {
        logic [CNT_W-1:0] odd_count;
        logic [CNT_W-1:0] total;
    } t_counts;

    logic [IN_W-1:0] pending_limits[$];
    t_counts         expected_counts[$];
    int              odd_primes_upto[];
    logic [PC_W-1:0] part_count_reg = PC_W'(1);
    logic [PI_W-1:0] part_index_reg = '0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              hold_cycles = 0;
    int              mismatches = 0;
    int              cycle_count = 0;
    bit              running = 1'b0;

    segmented_odd_prime_sieve_count_core #(
        .MAX_N(MAX_N),
        .MAX_PARTS(MAX_PARTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_limit_n(i_limit_n),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_odd_prime_count(o_odd_prime_count),
        .o_prime_count_total(o_prime_count_total),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_counts share_counts(input logic [IN_W-1:0] limit);
        longint n;
        longint parts;
        longint idx;
        longint lo;
        longint hi;
        longint cnt;
        t_counts res;
        n = longint'(limit);
        parts = longint'(part_count_reg);
        idx = longint'(part_index_reg);
        cnt = 0;
        if (n > MAX_N) n = MAX_N;
        if (n < 2) n = 2;
        if (parts == 0) parts = 1;
        if (parts > MAX_PARTS) parts = MAX_PARTS;
        if (idx < parts) begin
            lo = 2 + idx * (n - 1) / parts;
            if (lo[0] == 1'b0) lo++;
            hi = 1 + (idx + 1) * (n - 1) / parts;
            if (hi[0] == 1'b0) hi--;
            if (lo <= hi) cnt = longint'(odd_primes_upto[hi] - odd_primes_upto[lo - 1]);
        end
        res.odd_count = CNT_W'(cnt);
        res.total = CNT_W'(cnt + 1);
        return res;
    endfunction

    task automatic write_reg(input logic reg_sel, input int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_sel == REG_PART_COUNT) part_count_reg = PC_W'(value);
        else part_index_reg = PI_W'(value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input int parts, input int idx, input int send_pct,
                             input int stall_pct);
        repeat (20) @(posedge i_clk);
        write_reg(REG_PART_COUNT, parts);
        write_reg(REG_PART_INDEX, idx);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic drain;
        while (pending_limits.size() != 0 || i_valid || expected_counts.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (running) begin
            if (!i_valid || o_ready) begin
                if (pending_limits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_limit_n <= pending_limits.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_counts want;
        if (i_valid && o_ready) expected_counts.push_back(share_counts(i_limit_n));
        if (o_valid && i_ready) begin
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: odd %0d total %0d",
                             o_odd_prime_count, o_prime_count_total);
            end else begin
                want = expected_counts.pop_front();
                if (want.odd_count !== o_odd_prime_count || want.total !== o_prime_count_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected odd %0d total %0d, got odd %0d total %0d",
                                 want.odd_count, want.total,
                                 o_odd_prime_count, o_prime_count_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("segmented_odd_prime_sieve_count_core regression: fail");
            $finish;
        end
    end

    initial begin
        bit composite[];
        int acc;
        logic [IN_W-1:0] directed[$];
        composite = new[MAX_N + 1];
        odd_primes_upto = new[MAX_N + 1];
        for (longint p = 3; p * p <= MAX_N; p += 2)
            if (!composite[p])
                for (longint v = p * p; v <= MAX_N; v += 2 * p) composite[v] = 1'b1;
        acc = 0;
        for (int v = 0; v <= MAX_N; v++) begin
            if (v >= 3 && v[0] && !composite[v]) acc++;
            odd_primes_upto[v] = acc;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        directed = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 121, 1024, 4093, MAX_N};
        foreach (directed[k]) pending_limits.push_back(directed[k]);
        drain();

        run_phase(4, 3, 50, 0);
        repeat (15) pending_limits.push_back(IN_W'($urandom_range(4095)));
        drain();

        run_phase(0, 0, 0, 50);
        repeat (15) pending_limits.push_back(IN_W'($urandom_range(4095)));
        drain();

        run_phase(127, 63, 8, 8);
        repeat (15) pending_limits.push_back(IN_W'($urandom_range(8191)));
        drain();

        run_phase(64, 0, 0, 0);
        pending_limits.push_back(IN_W'((1 << IN_W) - 1));
        pending_limits.push_back(IN_W'(MAX_N + 1));
        repeat (20) pending_limits.push_back(IN_W'($urandom_range((1 << IN_W) - 1)));
        drain();

        run_phase(64, 1, 0, 0);
        repeat (5) pending_limits.push_back(IN_W'($urandom_range((1 << IN_W) - 1)));
        drain();

        run_phase(5, 9, 0, 0);
        repeat (5) pending_limits.push_back(IN_W'($urandom_range(4095)));
        drain();

        run_phase(3, 1, 0, 0);
        hold_cycles = 3000;
        repeat (15) pending_limits.push_back(IN_W'($urandom_range(600)));
        drain();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("segmented_odd_prime_sieve_count_core regression: pass");
        end else begin
            $display("segmented_odd_prime_sieve_count_core regression: fail");
        end
        $finish;
    end
endmodule
